// ===== rtl/core/hts_pkg.sv =====
// Shared types and constants for the HTML token scanner.
// Holds the item structs, the scanner state encoding, the event kinds and
// the byte codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

	// Default widths of the length counters and the byte position
	localparam int LENGTH_BITS_DEF   = 16;
	localparam int POSITION_BITS_DEF = 32;

	// Fixed widths of the result fields
	localparam int OUT_START_BITS  = 32;
	localparam int OUT_LENGTH_BITS = 16;

	// Input item modes
	localparam logic MODE_BYTE  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// Event kinds
	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_TEXT  = 3'd1;
	localparam logic [2:0] EV_START = 3'd2;
	localparam logic [2:0] EV_END   = 3'd3;
	localparam logic [2:0] EV_ATTR  = 3'd4;
	localparam logic [2:0] EV_VALUE = 3'd5;

	// Byte codes
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	// Markup counter targets
	localparam logic [1:0] DASH_OPEN    = 2'd2;
	localparam logic [2:0] DOCTYPE_FULL = 3'd7;
	localparam logic [7:0] CDATA_OPEN   = 8'd3;
	localparam logic [7:0] CDATA_MAX    = 8'd255;

	// Scanner states, one-hot
	typedef enum logic [24:0] {
		ST_DATA           = 25'h0000001,
		ST_TAG_OPEN       = 25'h0000002,
		ST_TAG_NAME       = 25'h0000004,
		ST_CLOSE_OPEN     = 25'h0000008,
		ST_BEFORE_ATTR    = 25'h0000010,
		ST_ATTR_NAME      = 25'h0000020,
		ST_BEFORE_VALUE   = 25'h0000040,
		ST_AFTER_ATTR     = 25'h0000080,
		ST_VAL_DQ         = 25'h0000100,
		ST_VAL_SQ         = 25'h0000200,
		ST_VAL_UNQ        = 25'h0000400,
		ST_AFTER_VALUE    = 25'h0000800,
		ST_SLASH_TAG      = 25'h0001000,
		ST_SLASH_ATTR     = 25'h0002000,
		ST_MARKUP         = 25'h0004000,
		ST_BOGUS          = 25'h0008000,
		ST_CMT_START      = 25'h0010000,
		ST_CMT_START_DASH = 25'h0020000,
		ST_CMT            = 25'h0040000,
		ST_CMT_END_DASH   = 25'h0080000,
		ST_CMT_END        = 25'h0100000,
		ST_CMT_END_BANG   = 25'h0200000,
		ST_DOCTYPE        = 25'h0400000,
		ST_DOCTYPE_NAME   = 25'h0800000,
		ST_CDATA          = 25'h1000000
	} scan_state_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]                 event_kind;
		logic [OUT_START_BITS-1:0]  token_start;
		logic [OUT_LENGTH_BITS-1:0] token_length;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/html_token_scanner.sv =====
// HTML token scanner top level: input register, tokenizer state machine and
// result register. Depends on hts_pkg.
//
// Timing: an accepted byte is held in the input register (s1), and its result
// goes into the result register (s2); a stalled result holds both registers.
// Throughput: one byte per cycle while the result is not stalled; the whole
// state update for a byte is one pass of tokenizer logic between s1 and s2.
// Reset: arst_n clears both valid flags and puts the scanner in the data state
// with all counters and positions at zero.
`timescale 1ns / 1ps
`default_nettype none

module html_token_scanner
	import hts_pkg::*;
#(
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	localparam logic [LENGTH_BITS-1:0]   LenMax = '1;
	localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
	localparam logic [LENGTH_BITS-1:0]   LenOne = LENGTH_BITS'(1);

	// Pipeline registers
	logic      valid_s1, valid_s2;
	in_item_t  item_s1;
	out_item_t result_s2;
	logic      advance;

	// Scanner state
	scan_state_t              state_q, nxt_state;
	logic [LENGTH_BITS-1:0]   run_q, space_q, nl_q;
	logic [LENGTH_BITS-1:0]   nxt_run, nxt_space, nxt_nl;
	logic [1:0]               dash_q, nxt_dash;
	logic [2:0]               doc_q, nxt_doc;
	logic [7:0]               cdata_q, nxt_cdata;
	logic [POSITION_BITS-1:0] pos_q, nxt_pos, start_q, nxt_start;
	logic                     fslash_q, nxt_fslash, pend_q, nxt_pend;

	// Per-byte helpers
	logic [7:0]               c;
	logic                     is_sp, is_let, is_doc_let, fs_cur;
	logic [LENGTH_BITS-1:0]   run_inc, space_inc, nl_inc, text_len;
	logic [LENGTH_BITS+1:0]   text_sum;
	logic [1:0]               dash_p1;
	logic [2:0]               doc_p1;
	logic [7:0]               cdata_inc;
	logic [2:0]               tag_kind;

	// Event before width fitting
	logic [2:0]                  ev_kind;
	logic [POSITION_BITS-1:0]    ev_start;
	logic [LENGTH_BITS-1:0]      ev_len;
	logic [LENGTH_BITS+15:0]     ev_len_ext;
	logic [POSITION_BITS+31:0]   ev_start_ext;
	out_item_t                   result;

	// Handshake: s1 moves on when the result register is free or being taken
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_item  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// Scanner state update, one byte per transfer out of s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DATA;
			run_q    <= '0;
			space_q  <= '0;
			nl_q     <= '0;
			dash_q   <= '0;
			doc_q    <= '0;
			cdata_q  <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			fslash_q <= 1'b0;
			pend_q   <= 1'b1;
		end else if (advance) begin
			state_q  <= nxt_state;
			run_q    <= nxt_run;
			space_q  <= nxt_space;
			nl_q     <= nxt_nl;
			dash_q   <= nxt_dash;
			doc_q    <= nxt_doc;
			cdata_q  <= nxt_cdata;
			pos_q    <= nxt_pos;
			start_q  <= nxt_start;
			fslash_q <= nxt_fslash;
			pend_q   <= nxt_pend;
		end
	end

	// Byte classes and saturating counters
	always_comb begin
		c      = item_s1.data_byte;
		is_sp  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
		         (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
		is_let = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
		// letters of "doctype" in either case
		is_doc_let = (c == 8'h64) || (c == 8'h44) || (c == 8'h6F) || (c == 8'h4F) ||
		             (c == 8'h63) || (c == 8'h43) || (c == 8'h74) || (c == 8'h54) ||
		             (c == 8'h79) || (c == 8'h59) || (c == 8'h70) || (c == 8'h50) ||
		             (c == 8'h65) || (c == 8'h45);
		fs_cur    = pend_q ? (c == CH_SLASH) : fslash_q;
		tag_kind  = fs_cur ? EV_END : EV_START;
		run_inc   = (run_q == LenMax) ? run_q : run_q + LenOne;
		space_inc = (space_q == LenMax) ? space_q : space_q + LenOne;
		nl_inc    = (nl_q == LenMax) ? nl_q : nl_q + LenOne;
		text_sum  = {2'b00, run_q} + {2'b00, space_q} + {2'b00, nl_q};
		text_len  = (text_sum > {2'b00, LenMax}) ? LenMax : text_sum[LENGTH_BITS-1:0];
		dash_p1   = dash_q + 2'd1;
		doc_p1    = doc_q + 3'd1;
		cdata_inc = (cdata_q == CDATA_MAX) ? cdata_q : cdata_q + 8'd1;
	end

	// Tokenizer transition
	always_comb begin
		nxt_state  = state_q;
		nxt_run    = run_q;
		nxt_space  = space_q;
		nxt_nl     = nl_q;
		nxt_dash   = dash_q;
		nxt_doc    = doc_q;
		nxt_cdata  = cdata_q;
		nxt_pos    = pos_q;
		nxt_start  = start_q;
		nxt_fslash = fslash_q;
		nxt_pend   = pend_q;
		ev_kind    = EV_NONE;
		ev_start   = '0;
		ev_len     = '0;

		if (item_s1.mode == MODE_FLUSH) begin
			// flush pending text, keep state and positions
			if (run_q != '0) begin
				ev_kind  = EV_TEXT;
				ev_start = start_q;
				ev_len   = text_len;
			end
			nxt_run   = '0;
			nxt_space = '0;
			nxt_nl    = '0;
		end else begin
			nxt_pos    = pos_q + PosOne;
			nxt_fslash = fs_cur;
			nxt_pend   = 1'b0;

			unique case (state_q)
				ST_DATA: begin
					if (c == CH_LT) begin
						if (run_q != '0) begin
							ev_kind  = EV_TEXT;
							ev_start = start_q;
							ev_len   = text_len;
						end
						nxt_run   = run_inc;
						nxt_space = '0;
						nxt_nl    = '0;
						nxt_state = ST_TAG_OPEN;
					end else if (c == CH_CR || c == CH_LF || c == CH_FF) begin
						nxt_nl = nl_inc;
					end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT) begin
						nxt_space = space_inc;
					end else begin
						nxt_run = run_inc;
					end
				end
				ST_TAG_OPEN: begin
					if (c == CH_BANG) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_MARKUP;
					end else if (c == CH_SLASH || is_let) begin
						nxt_start = pos_q; nxt_run = LenOne;
						nxt_fslash = (c == CH_SLASH); nxt_pend = 1'b0;
						nxt_state = (c == CH_SLASH) ? ST_CLOSE_OPEN : ST_TAG_NAME;
					end else if (c == CH_GT) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_DATA;
					end else if (c == CH_QUEST) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_BOGUS;
					end else begin
						nxt_run   = run_inc;
						nxt_state = ST_DATA;
					end
				end
				ST_TAG_NAME: begin
					if (is_sp || c == CH_GT) begin
						if (run_q != '0) begin
							ev_kind = tag_kind; ev_start = start_q; ev_len = run_q;
						end
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = is_sp ? ST_BEFORE_ATTR : ST_DATA;
					end else begin
						nxt_run = run_inc;
						if (c == CH_SLASH) nxt_state = ST_SLASH_TAG;
					end
				end
				ST_CLOSE_OPEN: begin
					if (is_let) begin
						nxt_run = run_inc; nxt_state = ST_TAG_NAME;
					end else begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = (c == CH_GT) ? ST_DATA : ST_BOGUS;
					end
				end
				ST_BEFORE_ATTR: begin
					if (is_sp) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
					end else if (c == CH_GT) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_DATA;
					end else if (c == CH_SLASH) begin
						nxt_run = run_inc; nxt_state = ST_SLASH_TAG;
					end else if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_EQ || c == CH_LT) begin
						nxt_state = ST_ATTR_NAME;
					end else begin
						nxt_run = run_inc; nxt_state = ST_ATTR_NAME;
					end
				end
				ST_ATTR_NAME: begin
					if (c == CH_EQ || c == CH_GT || is_sp) begin
						// zero-length names are still reported
						ev_kind = EV_ATTR; ev_start = start_q; ev_len = run_q;
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = (c == CH_EQ) ? ST_BEFORE_VALUE :
						            (c == CH_GT) ? ST_DATA : ST_AFTER_ATTR;
					end else begin
						nxt_run = run_inc;
						if (c == CH_SLASH) nxt_state = ST_SLASH_ATTR;
					end
				end
				ST_BEFORE_VALUE: begin
					if (is_sp || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_GT) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						if (c == CH_DQUOTE) nxt_state = ST_VAL_DQ;
						else if (c == CH_SQUOTE) nxt_state = ST_VAL_SQ;
						else if (c == CH_GT) nxt_state = ST_DATA;
					end else begin
						nxt_run = run_inc; nxt_state = ST_VAL_UNQ;
					end
				end
				ST_AFTER_ATTR: begin
					if (is_sp) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
					end else if (c == CH_EQ) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_BEFORE_VALUE;
					end else if (c == CH_GT) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_DATA;
					end else if (is_let) begin
						nxt_run = run_inc; nxt_state = ST_ATTR_NAME;
					end else if (c == CH_SLASH) begin
						nxt_run = run_inc; nxt_state = ST_SLASH_TAG;
					end else begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_ATTR_NAME;
					end
				end
				ST_VAL_DQ, ST_VAL_SQ: begin
					if ((state_q == ST_VAL_DQ && c == CH_DQUOTE) ||
					    (state_q == ST_VAL_SQ && c == CH_SQUOTE)) begin
						if (run_q != '0) begin
							ev_kind = EV_VALUE; ev_start = start_q; ev_len = run_q;
						end
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_AFTER_VALUE;
					end else begin
						nxt_run = run_inc;
					end
				end
				ST_VAL_UNQ: begin
					if (is_sp || c == CH_GT) begin
						if (run_q != '0) begin
							ev_kind = EV_VALUE; ev_start = start_q; ev_len = run_q;
						end
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = is_sp ? ST_BEFORE_ATTR : ST_DATA;
					end else begin
						nxt_run = run_inc;
					end
				end
				ST_AFTER_VALUE: begin
					if (c == CH_SLASH) begin
						nxt_run = run_inc; nxt_state = ST_SLASH_TAG;
					end else begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = (c == CH_GT) ? ST_DATA : ST_BEFORE_ATTR;
					end
				end
				ST_SLASH_TAG: begin
					if (c == CH_GT) begin
						if (run_q != '0) begin
							ev_kind = tag_kind; ev_start = start_q; ev_len = run_q;
						end
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_DATA;
					end else if (is_sp) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_BEFORE_ATTR;
					end else begin
						// report the tag before the slash, restart at this byte
						if (run_q > LenOne) begin
							ev_kind = tag_kind; ev_start = start_q; ev_len = run_q - LenOne;
							nxt_start = pos_q; nxt_run = LenOne;
							nxt_fslash = (c == CH_SLASH); nxt_pend = 1'b0;
						end
						nxt_state = ST_BEFORE_ATTR;
					end
				end
				ST_SLASH_ATTR: begin
					if (c == CH_GT) begin
						if (run_q != '0) begin
							ev_kind = EV_ATTR; ev_start = start_q; ev_len = run_q;
						end
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_DATA;
					end else if (is_sp) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = ST_BEFORE_ATTR;
					end else begin
						nxt_run = run_inc; nxt_state = ST_BEFORE_ATTR;
					end
				end
				ST_MARKUP: begin
					if (c == CH_DASH) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_doc   = '0;
						nxt_cdata = '0;
						if (dash_p1 == DASH_OPEN) begin
							nxt_state = ST_CMT_START; nxt_dash = '0;
						end else begin
							nxt_dash = dash_p1;
						end
					end else if (is_doc_let) begin
						if (doc_p1 == DOCTYPE_FULL) begin
							nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
							nxt_state = ST_DOCTYPE; nxt_doc = '0;
						end else begin
							nxt_run = run_inc; nxt_doc = doc_p1;
						end
					end else if (c == CH_LBRACK || c == CH_UP_A) begin
						if (cdata_inc == CDATA_OPEN) begin
							nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
							nxt_state = ST_CDATA; nxt_cdata = '0;
						end else begin
							nxt_run = run_inc; nxt_cdata = cdata_inc;
						end
					end else begin
						nxt_run   = run_inc;
						nxt_dash  = '0;
						nxt_doc   = '0;
						nxt_cdata = '0;
						nxt_state = ST_DATA;
					end
				end
				ST_BOGUS: begin
					nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
					if (c == CH_GT) nxt_state = ST_DATA;
				end
				ST_CMT_START, ST_CMT_START_DASH, ST_CMT, ST_CMT_END_DASH: begin
					nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
					if (c == CH_DASH) begin
						if (state_q == ST_CMT_START) nxt_state = ST_CMT_START_DASH;
						else if (state_q == ST_CMT) nxt_state = ST_CMT_END_DASH;
						else nxt_state = ST_CMT_END;
					end
				end
				ST_CMT_END: begin
					if (c == CH_GT || c == CH_BANG) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						nxt_state = (c == CH_GT) ? ST_DATA : ST_CMT_END_BANG;
					end
				end
				ST_CMT_END_BANG: begin
					nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
					if (c == CH_GT) nxt_state = ST_DATA;
					else if (c != CH_BANG) nxt_state = ST_CMT;
				end
				ST_DOCTYPE: begin
					nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
					nxt_state = ST_DOCTYPE_NAME;
				end
				ST_DOCTYPE_NAME: begin
					if (is_sp || c == CH_GT) begin
						nxt_start = pos_q + PosOne; nxt_run = '0; nxt_pend = 1'b1;
						if (c == CH_GT) nxt_state = ST_DATA;
					end else begin
						nxt_run = run_inc;
					end
				end
				ST_CDATA: begin
					// count bytes since ']'; a '>' one byte after it closes
					if (c == CH_RBRACK || cdata_q != '0) begin
						if (c == CH_GT) begin
							if (cdata_q == 8'd1) nxt_state = ST_DATA;
							nxt_cdata = 8'd1;
						end else begin
							nxt_cdata = cdata_inc;
						end
					end
				end
				default: begin
					nxt_state = ST_DATA;
				end
			endcase
		end
	end

	// Fit the event to the result field widths
	always_comb begin
		ev_len_ext   = {16'b0, ev_len};
		ev_start_ext = {32'b0, ev_start};
		result.event_kind   = ev_kind;
		result.token_start  = ev_start_ext[OUT_START_BITS-1:0];
		result.token_length = (ev_len_ext > (LENGTH_BITS + 16)'(16'hFFFF)) ?
		                      16'hFFFF : ev_len_ext[OUT_LENGTH_BITS-1:0];
	end

endmodule

`default_nettype wire

// ===== test/tb_html_token_scanner.sv =====
// Self-checking testbench for the HTML token scanner (html_token_scanner).
// Drives byte and flush transfers under random backpressure, predicts every result
// with a scoreboard class and compares field by field. Depends on hts_pkg and the RTL.
`timescale 1ns / 1ps

module tb_html_token_scanner;
	import hts_pkg::*;

	localparam int    CYCLE_LIMIT   = 1_000_000;
	localparam int    RANDOM_ITEMS  = 840;
	localparam int    LONG_RUN      = 40;
	localparam int    DRAIN_CYCLES  = 10;
	localparam int    IDLE_PERCENT  = 9;
	localparam int    REPORT_LIMIT  = 10;
	localparam string DOCTYPE_WORD  = "doctype";

	// Token predictor and store of expected results
	class token_scoreboard;
		out_item_t   expected_q[$];
		int unsigned mismatches;
		scan_state_t st;
		logic [15:0] run_len;
		logic [15:0] spaces;
		logic [15:0] newlines;
		logic [1:0]  dashes;
		logic [2:0]  doctype_cnt;
		logic [7:0]  cdata_cnt;
		logic [31:0] byte_pos;
		logic [31:0] start_pos;
		logic        first_slash;
		logic        capture_pending;

		function new();
			mismatches      = 0;
			st              = ST_DATA;
			run_len         = '0;
			spaces          = '0;
			newlines        = '0;
			dashes          = '0;
			doctype_cnt     = '0;
			cdata_cnt       = '0;
			byte_pos        = '0;
			start_pos       = '0;
			first_slash     = 1'b0;
			capture_pending = 1'b1;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [15:0] sat_inc(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function logic is_blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
				c == CH_FF || c == CH_CR;
		endfunction

		function logic is_alpha(logic [7:0] c);
			return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
		endfunction

		// Letters of the doctype keyword, either case
		function logic is_doctype_letter(logic [7:0] c);
			logic [7:0] low;
			low = c | 8'h20;
			if (!is_alpha(c))
				return 1'b0;
			for (int i = 0; i < DOCTYPE_WORD.len(); i++)
				if (low == DOCTYPE_WORD[i])
					return 1'b1;
			return 1'b0;
		endfunction

		// Text length is the sum of the three counters, saturated
		function logic [15:0] text_total();
			logic [17:0] sum;
			sum = 18'(run_len) + 18'(spaces) + 18'(newlines);
			return (sum > 18'h0FFFF) ? 16'hFFFF : sum[15:0];
		endfunction

		function out_item_t make_event(logic [2:0] kind, logic [15:0] len);
			out_item_t r;
			r.event_kind   = kind;
			r.token_start  = start_pos;
			r.token_length = len;
			return r;
		endfunction

		function out_item_t tag_event(logic [15:0] len);
			return make_event(first_slash ? EV_END : EV_START, len);
		endfunction

		// Token begins at the byte after this one
		function void restart_next();
			start_pos       = byte_pos + 32'd1;
			run_len         = '0;
			capture_pending = 1'b1;
		endfunction

		// Token begins at this byte, which is counted
		function void restart_here(logic [7:0] c);
			start_pos       = byte_pos;
			run_len         = 16'd1;
			first_slash     = (c == CH_SLASH);
			capture_pending = 1'b0;
		endfunction

		// Advance the predictor by one accepted input transfer
		function void note_input(in_item_t it);
			logic [7:0] c;
			logic       sp;
			logic       ltr;
			out_item_t  r;
			c   = it.data_byte;
			sp  = is_blank(c);
			ltr = is_alpha(c);
			r   = '0;

			if (it.mode == MODE_FLUSH) begin
				if (run_len != 0)
					r = make_event(EV_TEXT, text_total());
				run_len  = '0;
				spaces   = '0;
				newlines = '0;
				expected_q.push_back(r);
				return;
			end

			if (capture_pending) begin
				first_slash     = (c == CH_SLASH);
				capture_pending = 1'b0;
			end

			case (st)
			ST_DATA: begin
				if (c == CH_LT) begin
					if (run_len != 0)
						r = make_event(EV_TEXT, text_total());
					run_len  = sat_inc(run_len);
					spaces   = '0;
					newlines = '0;
					st       = ST_TAG_OPEN;
				end else if (c == CH_CR || c == CH_LF || c == CH_FF) begin
					newlines = sat_inc(newlines);
				end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT) begin
					spaces = sat_inc(spaces);
				end else begin
					run_len = sat_inc(run_len);
				end
			end
			ST_TAG_OPEN: begin
				if (c == CH_BANG) begin
					restart_next();
					st = ST_MARKUP;
				end else if (c == CH_SLASH) begin
					restart_here(c);
					st = ST_CLOSE_OPEN;
				end else if (ltr) begin
					restart_here(c);
					st = ST_TAG_NAME;
				end else if (c == CH_GT) begin
					restart_next();
					st = ST_DATA;
				end else if (c == CH_QUEST) begin
					restart_next();
					st = ST_BOGUS;
				end else begin
					run_len = sat_inc(run_len);
					st      = ST_DATA;
				end
			end
			ST_TAG_NAME: begin
				if (sp || c == CH_GT) begin
					if (run_len != 0)
						r = tag_event(run_len);
					restart_next();
					st = sp ? ST_BEFORE_ATTR : ST_DATA;
				end else begin
					run_len = sat_inc(run_len);
					if (c == CH_SLASH)
						st = ST_SLASH_TAG;
				end
			end
			ST_CLOSE_OPEN: begin
				if (ltr) begin
					run_len = sat_inc(run_len);
					st      = ST_TAG_NAME;
				end else begin
					restart_next();
					st = (c == CH_GT) ? ST_DATA : ST_BOGUS;
				end
			end
			ST_BEFORE_ATTR: begin
				if (sp) begin
					restart_next();
				end else if (c == CH_GT) begin
					restart_next();
					st = ST_DATA;
				end else if (c == CH_SLASH) begin
					run_len = sat_inc(run_len);
					st      = ST_SLASH_TAG;
				end else if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_EQ || c == CH_LT) begin
					st = ST_ATTR_NAME;
				end else begin
					run_len = sat_inc(run_len);
					st      = ST_ATTR_NAME;
				end
			end
			ST_ATTR_NAME: begin
				if (c == CH_EQ || c == CH_GT || sp) begin
					r = make_event(EV_ATTR, run_len);
					restart_next();
					st = (c == CH_EQ) ? ST_BEFORE_VALUE : (c == CH_GT) ? ST_DATA : ST_AFTER_ATTR;
				end else begin
					run_len = sat_inc(run_len);
					if (c == CH_SLASH)
						st = ST_SLASH_ATTR;
				end
			end
			ST_BEFORE_VALUE: begin
				if (sp) begin
					restart_next();
				end else if (c == CH_DQUOTE) begin
					restart_next();
					st = ST_VAL_DQ;
				end else if (c == CH_SQUOTE) begin
					restart_next();
					st = ST_VAL_SQ;
				end else if (c == CH_GT) begin
					restart_next();
					st = ST_DATA;
				end else begin
					run_len = sat_inc(run_len);
					st      = ST_VAL_UNQ;
				end
			end
			ST_AFTER_ATTR: begin
				if (sp) begin
					restart_next();
				end else if (c == CH_EQ) begin
					restart_next();
					st = ST_BEFORE_VALUE;
				end else if (c == CH_GT) begin
					restart_next();
					st = ST_DATA;
				end else if (ltr) begin
					run_len = sat_inc(run_len);
					st      = ST_ATTR_NAME;
				end else if (c == CH_SLASH) begin
					run_len = sat_inc(run_len);
					st      = ST_SLASH_TAG;
				end else begin
					restart_next();
					st = ST_ATTR_NAME;
				end
			end
			ST_VAL_DQ, ST_VAL_SQ: begin
				if ((st == ST_VAL_DQ && c == CH_DQUOTE) || (st == ST_VAL_SQ && c == CH_SQUOTE)) begin
					if (run_len != 0)
						r = make_event(EV_VALUE, run_len);
					restart_next();
					st = ST_AFTER_VALUE;
				end else begin
					run_len = sat_inc(run_len);
				end
			end
			ST_VAL_UNQ: begin
				if (sp || c == CH_GT) begin
					if (run_len != 0)
						r = make_event(EV_VALUE, run_len);
					restart_next();
					st = sp ? ST_BEFORE_ATTR : ST_DATA;
				end else begin
					run_len = sat_inc(run_len);
				end
			end
			ST_AFTER_VALUE: begin
				if (c == CH_GT) begin
					restart_next();
					st = ST_DATA;
				end else if (c == CH_SLASH) begin
					run_len = sat_inc(run_len);
					st      = ST_SLASH_TAG;
				end else begin
					restart_next();
					st = ST_BEFORE_ATTR;
				end
			end
			ST_SLASH_TAG: begin
				if (c == CH_GT) begin
					if (run_len != 0)
						r = tag_event(run_len);
					restart_next();
					st = ST_DATA;
				end else if (sp) begin
					restart_next();
					st = ST_BEFORE_ATTR;
				end else begin
					// stray byte after the slash: report the tag, start over here
					if (run_len > 16'd1) begin
						r = tag_event(run_len - 16'd1);
						restart_here(c);
					end
					st = ST_BEFORE_ATTR;
				end
			end
			ST_SLASH_ATTR: begin
				if (c == CH_GT) begin
					if (run_len != 0)
						r = make_event(EV_ATTR, run_len);
					restart_next();
					st = ST_DATA;
				end else if (sp) begin
					restart_next();
					st = ST_BEFORE_ATTR;
				end else begin
					run_len = sat_inc(run_len);
					st      = ST_BEFORE_ATTR;
				end
			end
			ST_MARKUP: begin
				if (c == CH_DASH) begin
					restart_next();
					doctype_cnt = '0;
					cdata_cnt   = '0;
					dashes      = dashes + 2'd1;
					if (dashes == DASH_OPEN) begin
						st     = ST_CMT_START;
						dashes = '0;
					end
				end else if (is_doctype_letter(c)) begin
					doctype_cnt = doctype_cnt + 3'd1;
					run_len     = sat_inc(run_len);
					if (doctype_cnt == DOCTYPE_FULL) begin
						restart_next();
						st          = ST_DOCTYPE;
						doctype_cnt = '0;
					end
				end else if (c == CH_LBRACK || c == CH_UP_A) begin
					if (cdata_cnt < CDATA_MAX)
						cdata_cnt = cdata_cnt + 8'd1;
					run_len = sat_inc(run_len);
					if (cdata_cnt == CDATA_OPEN) begin
						restart_next();
						st        = ST_CDATA;
						cdata_cnt = '0;
					end
				end else begin
					run_len     = sat_inc(run_len);
					dashes      = '0;
					doctype_cnt = '0;
					cdata_cnt   = '0;
					st          = ST_DATA;
				end
			end
			ST_BOGUS: begin
				restart_next();
				if (c == CH_GT)
					st = ST_DATA;
			end
			ST_CMT_START, ST_CMT_START_DASH, ST_CMT, ST_CMT_END_DASH: begin
				restart_next();
				if (c == CH_DASH) begin
					if (st == ST_CMT_START)
						st = ST_CMT_START_DASH;
					else if (st == ST_CMT)
						st = ST_CMT_END_DASH;
					else
						st = ST_CMT_END;
				end
			end
			ST_CMT_END: begin
				if (c == CH_GT) begin
					restart_next();
					st = ST_DATA;
				end else if (c == CH_BANG) begin
					restart_next();
					st = ST_CMT_END_BANG;
				end
			end
			ST_CMT_END_BANG: begin
				restart_next();
				if (c == CH_GT)
					st = ST_DATA;
				else if (c != CH_BANG)
					st = ST_CMT;
			end
			ST_DOCTYPE: begin
				restart_next();
				st = ST_DOCTYPE_NAME;
			end
			ST_DOCTYPE_NAME: begin
				if (sp) begin
					restart_next();
				end else if (c == CH_GT) begin
					restart_next();
					st = ST_DATA;
				end else begin
					run_len = sat_inc(run_len);
				end
			end
			ST_CDATA: begin
				// count bytes from the first closing bracket; leave on bracket then '>'
				if (c == CH_RBRACK || cdata_cnt != 0) begin
					if (c == CH_GT) begin
						if (cdata_cnt == 8'd1)
							st = ST_DATA;
						cdata_cnt = '0;
					end
					if (cdata_cnt < CDATA_MAX)
						cdata_cnt = cdata_cnt + 8'd1;
				end
			end
			default: st = ST_DATA;
			endcase

			byte_pos = byte_pos + 32'd1;
			expected_q.push_back(r);
		endfunction

		// Compare one output transfer with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: kind %0d start %0d length %0d",
						got.event_kind, got.token_start, got.token_length);
				return;
			end
			want = expected_q.pop_front();
			if (got.event_kind !== want.event_kind || got.token_start !== want.token_start ||
				got.token_length !== want.token_length) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected kind %0d start %0d length %0d, got kind %0d start %0d length %0d",
						want.event_kind, want.token_start, want.token_length,
						got.event_kind, got.token_start, got.token_length);
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;

	token_scoreboard sb = new();
	in_item_t        doc_q[$];
	int unsigned     cycle_count = 0;
	int unsigned     items_sent  = 0;
	logic            steady      = 1'b0;

	html_token_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: stall at random unless in a steady stretch
	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Watch both channels and bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			if (arst_n && in_valid && in_ready)
				sb.note_input(in_item);
			if (arst_n && out_valid && out_ready)
				sb.check_result(out_item);
		end
	end

	// Document building
	function automatic void put_char(logic [7:0] b);
		in_item_t it;
		it.mode      = MODE_BYTE;
		it.data_byte = b;
		doc_q.push_back(it);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endfunction

	function automatic void put_flush();
		in_item_t it;
		it.mode      = MODE_FLUSH;
		it.data_byte = 8'($urandom_range(0, 255));
		doc_q.push_back(it);
	endfunction

	function automatic logic [7:0] pick_letter();
		logic [7:0] b;
		b = CH_LO_A + 8'($urandom_range(0, 25));
		if ($urandom_range(0, 1))
			b = b - (CH_LO_A - CH_UP_A);
		return b;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
		0: return CH_SPACE;
		1: return CH_TAB;
		2: return CH_LF;
		3: return CH_VT;
		4: return CH_FF;
		default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_text_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
		0, 1: b = pick_blank();
		2, 3: b = 8'($urandom_range(0, 255));
		default: b = pick_letter();
		endcase
		if (b == CH_LT)
			b = CH_GT;
		return b;
	endfunction

	// Any byte other than the one given
	function automatic logic [7:0] pick_other(logic [7:0] avoid);
		logic [7:0] b;
		b = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : pick_letter();
		return (b == avoid) ? pick_letter() : b;
	endfunction

	function automatic void put_name();
		repeat ($urandom_range(1, 6))
			put_char(pick_letter());
	endfunction

	function automatic void put_attr();
		logic [7:0] quote;
		put_char(pick_blank());
		// name: empty, with a slash inside, or plain letters
		case ($urandom_range(0, 7))
		0: put_char(CH_EQ);
		1: begin
			put_char(pick_letter());
			put_char(CH_SLASH);
			put_char(pick_letter());
		end
		default: put_name();
		endcase
		case ($urandom_range(0, 5))
		0: ;
		1, 2: begin
			quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
			put_char(CH_EQ);
			put_char(quote);
			repeat ($urandom_range(0, 6))
				put_char(pick_other(quote));
			put_char(quote);
		end
		default: begin
			put_char(CH_EQ);
			repeat ($urandom_range(1, 5))
				put_char(pick_letter());
		end
		endcase
	endfunction

	// One random fragment: mostly well-formed markup, some noise
	function automatic void build_fragment();
		logic [7:0] b;
		case ($urandom_range(0, 19))
		0, 1, 2, 3: begin
			repeat ($urandom_range(1, 12))
				put_char(pick_text_byte());
		end
		4, 5, 6, 7, 8: begin
			put_char(CH_LT);
			put_name();
			repeat ($urandom_range(0, 3))
				put_attr();
			if ($urandom_range(0, 3) == 0)
				put_char(CH_SLASH);
			if ($urandom_range(0, 9) == 0)
				put_char(pick_letter());
			put_char(CH_GT);
		end
		9, 10: begin
			put_char(CH_LT);
			put_char(CH_SLASH);
			put_name();
			if ($urandom_range(0, 3) == 0)
				put_char(pick_blank());
			put_char(CH_GT);
		end
		11: begin
			put_text("<!--");
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(0, 5))
				0: put_char(CH_DASH);
				1: put_char(CH_BANG);
				default: put_char(pick_letter());
				endcase
			end
			if ($urandom_range(0, 3) == 0)
				put_text("--!>");
			else
				put_text("-->");
		end
		12: begin
			if ($urandom_range(0, 1))
				put_text("<!DOCTYPE");
			else
				put_text("<!doctype");
			put_char(pick_blank());
			put_name();
			put_char(CH_GT);
		end
		13: begin
			put_text("<![CDATA[");
			repeat ($urandom_range(0, 8))
				put_char(pick_other(CH_RBRACK));
			put_char(CH_RBRACK);
			put_char(CH_GT);
		end
		14: begin
			put_char(CH_LT);
			put_char(CH_QUEST);
			repeat ($urandom_range(0, 6))
				put_char(pick_other(CH_GT));
			put_char(CH_GT);
		end
		15, 16: put_flush();
		17: begin
			repeat ($urandom_range(1, 4))
				put_char(8'($urandom_range(0, 255)));
		end
		18: begin
			// broken markup start
			put_char(CH_LT);
			case ($urandom_range(0, 7))
			0: b = CH_LT;
			1: b = CH_BANG;
			2: b = CH_SLASH;
			3: b = CH_DASH;
			4: b = CH_EQ;
			5: b = CH_SQUOTE;
			6: b = CH_DQUOTE;
			default: b = CH_GT;
			endcase
			put_char(b);
		end
		default: begin
			repeat ($urandom_range(20, 60))
				put_char(pick_text_byte());
		end
		endcase
	endfunction

	// Present one transfer, idling first at random
	task automatic send_item(input in_item_t it);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_doc();
		while (doc_q.size() != 0)
			send_item(doc_q.pop_front());
	endtask

	// Hold the sender until every expected result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned target;
		logic [7:0]  b;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero byte, stray byte after a tag slash, empty attribute name,
		// all-ones value byte, end tag, flush, doctype
		put_char(8'h00);
		put_text("<a/x ==");
		put_char(8'hFF);
		put_char(CH_GT);
		put_text("</b>");
		put_flush();
		put_text("<!doctype>>");
		send_doc();
		wait_drained();

		// One long text run with trailing blanks ahead of a tag
		for (int i = 0; i < LONG_RUN; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_LT || b == CH_SPACE || b == CH_TAB || b == CH_VT ||
				b == CH_LF || b == CH_FF || b == CH_CR)
				b = pick_letter();
			put_char(b);
		end
		repeat (20)
			put_char(pick_blank());
		put_text("<p>");
		put_flush();
		send_doc();
		wait_drained();

		// Random documents, with a steady stretch and a drain midway
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			steady = (target - items_sent < 600) && (target - items_sent > 400);
			build_fragment();
			send_doc();
			if (target - items_sent < 450 && target - items_sent > 430)
				wait_drained();
		end
		steady = 1'b0;
		put_flush();
		send_doc();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
